[hw/rtl/gvns_pkg.sv]
// Package for the grid visit novelty scorer: sizes, codes and command/status types.
// No dependencies.
package gvns_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW = $clog2(MaxRows);
    localparam int ColW = $clog2(MaxCols);
    localparam int AddrW = RowW + ColW;
    localparam int Depth = MaxRows * MaxCols;
    localparam int CntW = 32;
    localparam int DistW = 8;
    localparam int ProdW = CntW + DistW + 16;   // count * dist << 16
    localparam int RootW = ProdW / 2;
    localparam int SumW = RootW + AddrW;
    localparam int NovW = 18;
    localparam logic [NovW-1:0] NovMax = {NovW{1'b1}};

    localparam logic [1:0] KIND_SCORE  = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_BOTH   = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic clear_step;   // write zero at sweep address, advance
        logic load;         // latch input item
        logic scan_start;   // reset scan counters and sum
        logic div_start;    // begin sum / total
        logic rec_read;     // read cell for record
        logic rec_write;    // write incremented cell, bump total
        logic out_load;     // load result register
    } gvns_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;    // all cells issued and pipe drained
        logic div_done;
        logic hist_empty;
        logic do_score;
        logic do_record;
        logic kind_valid;
    } gvns_sts_t;
endpackage

[hw/rtl/gvns_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on gvns_pkg.
module gvns_sqrt
    import gvns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ProdW-1:0] radicand,
    output logic             out_valid,
    output logic [RootW-1:0] root
);
    logic [RootW:0]   valid_reg;
    logic [ProdW+1:0] rem_reg  [RootW+1];
    logic [RootW-1:0] res_reg  [RootW+1];
    logic [ProdW-1:0] rad_reg  [RootW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[RootW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        res_reg[0] <= '0;
        rad_reg[0] <= radicand;
    end

    // Digit-by-digit: bring down two radicand bits, try (4*res+1).
    for (genvar s = 0; s < RootW; s++)
    begin : g_stage
        logic [ProdW+1:0] rem_sh;
        logic [ProdW+1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[s][ProdW-1:0], rad_reg[s][ProdW-1-2*s -: 2]};
            trial  = {{(ProdW+2-RootW-2){1'b0}}, res_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            rad_reg[s+1] <= rad_reg[s];
            if (rem_sh >= trial)
            begin
                rem_reg[s+1] <= rem_sh - trial;
                res_reg[s+1] <= {res_reg[s][RootW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= rem_sh;
                res_reg[s+1] <= {res_reg[s][RootW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[RootW];
    assign root = res_reg[RootW];
endmodule

[hw/rtl/gvns_datapath.sv]
// Datapath: histogram memory, cell scan, root pipe, accumulator, divider, result.
// Depends on gvns_pkg and gvns_sqrt.
module gvns_datapath
    import gvns_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  gvns_cmd_t       cmd,
    output gvns_sts_t       sts,
    input  logic [1:0]      in_kind,
    input  logic [RowW-1:0] in_row,
    input  logic [ColW-1:0] in_col,
    input  logic [6:0]      rows_cfg,
    input  logic [6:0]      cols_cfg,
    output logic [NovW-1:0] novelty,
    output logic            history_empty
);
    logic [CntW-1:0] mem [Depth];
    logic [AddrW:0]  clr_reg;
    logic [1:0]      kind_reg;
    logic [RowW-1:0] prow_reg;
    logic [ColW-1:0] pcol_reg;
    logic [CntW-1:0] total_reg;
    logic [AddrW:0]  scan_reg;       // issue index, MSB = done issuing
    logic            issue_q_reg;
    logic [DistW-1:0] dist_q_reg;
    logic            in_grid_q_reg;
    logic [CntW-1:0] rd_reg;
    logic            prod_v_reg;
    logic [ProdW-1:0] prod_reg;
    logic            root_v;
    logic [RootW-1:0] root;
    logic [SumW-1:0] sum_reg;
    logic [7:0]      drain_reg;
    logic [SumW-1:0] quo_reg;
    logic [CntW:0]   rem_reg;
    logic [$clog2(SumW+1)-1:0] div_cnt_reg;
    logic            div_busy_reg;
    logic            div_done_reg;

    logic [6:0] nr, nc;
    logic       rec_ok;
    logic [RowW-1:0] s_row;
    logic [ColW-1:0] s_col;
    logic       issue;
    logic [RowW:0] dr;
    logic [ColW:0] dc;
    logic [AddrW-1:0] rec_addr;

    always_comb
    begin
        nr = (rows_cfg > 7'(MaxRows)) ? 7'(MaxRows) : rows_cfg;
        nc = (cols_cfg > 7'(MaxCols)) ? 7'(MaxCols) : cols_cfg;
        rec_ok = ({1'b0, prow_reg} < nr) && ({1'b0, pcol_reg} < nc);
        s_row = scan_reg[AddrW-1:ColW];
        s_col = scan_reg[ColW-1:0];
        issue = !scan_reg[AddrW];
        dr = (s_row > prow_reg) ? {1'b0, s_row - prow_reg} : {1'b0, prow_reg - s_row};
        dc = (s_col > pcol_reg) ? {1'b0, s_col - pcol_reg} : {1'b0, pcol_reg - s_col};
        rec_addr = {prow_reg, pcol_reg};
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_reg[AddrW-1:0]] <= '0;
        end
        else if (cmd.rec_write && rec_ok && rd_reg != '1)
        begin
            mem[rec_addr] <= rd_reg + 1'b1;
        end
        rd_reg <= mem[cmd.rec_read ? rec_addr : scan_reg[AddrW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            total_reg <= '0;
            scan_reg <= {1'b1, {AddrW{1'b0}}};
            issue_q_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            drain_reg <= '0;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            kind_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                kind_reg <= in_kind;
            end
            if (cmd.rec_write && rec_ok && total_reg != '1)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                drain_reg <= '0;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            else if (drain_reg != 8'(RootW + 4))
            begin
                drain_reg <= drain_reg + 1'b1;
            end
            issue_q_reg <= issue && !cmd.scan_start;
            prod_v_reg <= issue_q_reg;
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg && div_cnt_reg == 1)
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prow_reg <= in_row;
            pcol_reg <= in_col;
        end
        dist_q_reg <= DistW'(dr) + DistW'(dc);
        in_grid_q_reg <= ({1'b0, s_row} < nr) && ({1'b0, s_col} < nc);
        prod_reg <= in_grid_q_reg ? ({ProdW'(rd_reg) * ProdW'(dist_q_reg)} << 16) : '0;
        if (cmd.scan_start)
        begin
            sum_reg <= '0;
        end
        else if (root_v)
        begin
            sum_reg <= sum_reg + SumW'(root);
        end
    end

    gvns_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_v_reg),
        .radicand  (prod_reg),
        .out_valid (root_v),
        .root      (root)
    );

    // Restoring divider, one quotient bit per cycle.
    logic [CntW:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[CntW-1:0], quo_reg[SumW-1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
            div_cnt_reg <= ($clog2(SumW+1))'(SumW);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, total_reg})
            begin
                rem_reg <= rem_sh - {1'b0, total_reg};
                quo_reg <= {quo_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SumW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            history_empty <= (total_reg == '0);
            if (total_reg == '0)
            begin
                novelty <= '0;
            end
            else if (quo_reg > SumW'(NovMax))
            begin
                novelty <= NovMax;
            end
            else
            begin
                novelty <= quo_reg[NovW-1:0];
            end
        end
    end

    always_comb
    begin
        sts.clear_done = clr_reg[AddrW];
        sts.scan_done  = scan_reg[AddrW] && drain_reg == 8'(RootW + 4);
        sts.div_done   = div_done_reg;
        sts.hist_empty = (total_reg == '0);
        sts.do_score   = (kind_reg == KIND_SCORE) || (kind_reg == KIND_BOTH);
        sts.do_record  = (kind_reg == KIND_RECORD) || (kind_reg == KIND_BOTH);
        sts.kind_valid = sts.do_score || sts.do_record;
    end
endmodule

[hw/rtl/gvns_ctrl.sv]
// Controller FSM: clearing sweep, scan, divide, record, output handshake.
// Depends on gvns_pkg.
module gvns_ctrl
    import gvns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_tvalid,
    output logic      in_tready,
    output logic      out_tvalid,
    input  logic      out_tready,
    output gvns_cmd_t cmd,
    input  gvns_sts_t sts
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_OUT   = 9'b000100000,
        S_RREAD = 9'b001000000,
        S_RWAIT = 9'b010000000,
        S_RWR   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_tready;
    assign in_tready = (state_reg == S_IDLE);
    assign out_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_tready;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clear_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.do_score && !sts.hist_empty)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else if (sts.do_score)
                begin
                    state_next = S_OUT;
                end
                else if (sts.kind_valid)
                begin
                    state_next = S_RREAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = sts.do_record ? S_RREAD : S_IDLE;
                end
            end
            S_RREAD:
            begin
                cmd.rec_read = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                // keep the read port on the record cell so the data holds
                cmd.rec_read = 1'b1;
                state_next = S_RWR;
            end
            S_RWR:
            begin
                cmd.rec_write = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_tready |-> !sts.clear_done || state_reg == S_IDLE)
        else $error("ready outside idle");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_tready) |-> !cmd.out_load)
        else $error("result overwritten");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_tready)
        else $error("accept during clear");
    a_div_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.scan_done)
        else $error("divide before scan done");
`endif
endmodule

[hw/rtl/grid_visit_novelty_scorer_top.sv]
// Channel  | dir | tdata (low bit up)                 | tuser
// s_axis   | in  | [1:0] kind, [7:2] row, [13:8] col  | -
// m_axis   | out | [17:0] novelty                     | [0] history_empty
// cfg      | in  | wr_en, wr_index (0 rows, 1 cols), wr_data[6:0]
// A score on a non-empty history runs decode, a scan (one cell per cycle through
// the root pipe), divide and result load; a record alone: decode, read, wait, write.
// After reset a sweep clears the histogram; no item is accepted then.
// One item at a time; the result register frees the input while a result waits.
// Depends on gvns_pkg, gvns_ctrl, gvns_datapath.
module grid_visit_novelty_scorer_top
    import gvns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // kind, row, col
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // novelty
    output logic        m_axis_tuser,   // history_empty
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [6:0]  wr_data
);
    gvns_cmd_t  cmd;
    gvns_sts_t  sts;
    logic [6:0] rows_reg, cols_reg;
    logic [NovW-1:0] novelty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 7'(MaxRows);
            cols_reg <= 7'(MaxCols);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ROWS: rows_reg <= wr_data;
                CFG_COLS: cols_reg <= wr_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    gvns_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .cmd        (cmd),
        .sts        (sts)
    );

    gvns_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (s_axis_tdata[1:0]),
        .in_row        (s_axis_tdata[7:2]),
        .in_col        (s_axis_tdata[13:8]),
        .rows_cfg      (rows_reg),
        .cols_cfg      (cols_reg),
        .novelty       (novelty),
        .history_empty (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, novelty};
endmodule

[sim/tb_grid_visit_novelty_scorer_top.sv]
// Testbench for grid_visit_novelty_scorer_top: directed and random visit/score items,
// with a behavioral histogram scorer predicting each novelty result.
// Depends on gvns_pkg and the scorer RTL.
`timescale 1ns / 1ps
module tb_grid_visit_novelty_scorer_top;
    import gvns_pkg::*;

    typedef struct packed {
        logic [17:0] novelty;
        logic        history_empty;
    } score_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        wr_en = 1'b0;
    logic        wr_index = 1'b0;
    logic [6:0]  wr_data = '0;

    logic [31:0] hist_counts [0:Depth-1];
    logic [31:0] hist_total;
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    score_t      scores_pending [$];
    int          errors = 0;
    bit          calm = 1'b0;       // no idling on either side while set

    grid_visit_novelty_scorer_top u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] isqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic score_t novelty_of(input int prow, input int pcol);
        score_t s;
        int nr;
        int nc;
        logic [63:0] sum;
        logic [63:0] q;
        logic [63:0] span;
        nr = (rows_reg > MaxRows) ? MaxRows : rows_reg;
        nc = (cols_reg > MaxCols) ? MaxCols : cols_reg;
        sum = 0;
        if (hist_total == 0)
        begin
            s.novelty = '0;
            s.history_empty = 1'b1;
            return s;
        end
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (hist_counts[r*MaxCols + c] != 0)
                begin
                    span = ((r > prow) ? r - prow : prow - r)
                         + ((c > pcol) ? c - pcol : pcol - c);
                    sum += isqrt((64'(hist_counts[r*MaxCols + c]) * span) << 16);
                end
        q = sum / hist_total;
        s.novelty = (q > 64'(NovMax)) ? NovMax : q[17:0];
        s.history_empty = 1'b0;
        return s;
    endfunction

    function automatic void record_visit(input int prow, input int pcol);
        int nr;
        int nc;
        nr = (rows_reg > MaxRows) ? MaxRows : rows_reg;
        nc = (cols_reg > MaxCols) ? MaxCols : cols_reg;
        if (prow >= nr || pcol >= nc)
            return;
        if (hist_counts[prow*MaxCols + pcol] != 32'hFFFF_FFFF)
            hist_counts[prow*MaxCols + pcol]++;
        if (hist_total != 32'hFFFF_FFFF)
            hist_total++;
    endfunction

    // tvalid stays up after a transfer until the next idle cycle or a drain
    task automatic send_item(input logic [1:0] kind, input logic [5:0] row,
                             input logic [5:0] col);
        while (!calm && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {2'b00, col, row, kind};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kind == KIND_SCORE || kind == KIND_BOTH)
            scores_pending = {scores_pending, novelty_of(row, col)};
        if (kind == KIND_RECORD || kind == KIND_BOTH)
            record_visit(row, col);
        @(negedge clk);
    endtask

    task automatic drain_and_set(input logic idx, input logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        while (scores_pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_ROWS)
            rows_reg = value;
        else
            cols_reg = value;
    endtask

    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 11);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (scores_pending.size() == 0)
            begin
                $error("unexpected result transfer novelty=%0d", m_axis_tdata[17:0]);
                errors++;
            end
            else
            begin
                score_t e;
                e = scores_pending.pop_front();
                if (m_axis_tdata[17:0] !== e.novelty)
                begin
                    $error("novelty exp %0d got %0d", e.novelty, m_axis_tdata[17:0]);
                    errors++;
                end
                if (m_axis_tuser !== e.history_empty)
                begin
                    $error("history_empty exp %0d got %0d", e.history_empty,
                           m_axis_tuser);
                    errors++;
                end
            end
        end

    task automatic test_empty_history();
        send_item(KIND_SCORE, 6'd0, 6'd0);
        send_item(KIND_BOTH, 6'd63, 6'd63);     // scores before the visit
        send_item(KIND_SCORE, 6'd63, 6'd63);
        send_item(KIND_SCORE, 6'd0, 6'd0);
        send_item(2'd3, 6'd5, 6'd5);            // unknown kind is ignored
    endtask

    task automatic test_small_grid();
        drain_and_set(CFG_ROWS, 7'd1);
        drain_and_set(CFG_COLS, 7'd1);
        send_item(KIND_RECORD, 6'd0, 6'd0);
        send_item(KIND_RECORD, 6'd3, 6'd0);     // outside grid, dropped
        send_item(KIND_SCORE, 6'd63, 6'd42);    // scoring from outside the grid
        drain_and_set(CFG_ROWS, 7'd0);
        send_item(KIND_BOTH, 6'd0, 6'd0);       // empty grid sums to zero
        drain_and_set(CFG_ROWS, 7'd127);        // acts as the maximum
        drain_and_set(CFG_COLS, 7'd64);
        send_item(KIND_BOTH, 6'd21, 6'd63);
        send_item(KIND_SCORE, 6'd42, 6'd21);
        drain_and_set(CFG_COLS, 7'd8);          // shrunk grid keeps counts
        send_item(KIND_SCORE, 6'd0, 6'd0);
    endtask

    task automatic test_random_items();
        for (int i = 0; i < 140; i++)
        begin
            calm = (i >= 60 && i < 90);
            if (i == 100)
                drain_and_set(CFG_ROWS, 7'($urandom_range(1, 16)));
            if (i == 120)
                drain_and_set(CFG_COLS, 7'($urandom_range(1, 64)));
            send_item(($urandom_range(99) < 3) ? 2'd3 : 2'($urandom_range(2)),
                      6'($urandom), 6'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < Depth; i++)
            hist_counts[i] = '0;
        hist_total = '0;
        rows_reg = 7'd64;
        cols_reg = 7'd64;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_empty_history();
        test_small_grid();
        test_random_items();
        s_axis_tvalid <= 1'b0;
        while (scores_pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end
endmodule
